FILE: hdl/pdrm_pkg.sv
// ----------------------------------------------------------------------------
// pdrm_pkg
// Shared types, widths and codes of the point to display region mapper.
// ----------------------------------------------------------------------------
package pdrm_pkg;

  localparam int ENTRIES_DEF = 8;
  localparam int CFG_W       = 4;
  localparam int SLOT_W      = 3;
  localparam int COORD_W     = 16;
  localparam int SIZE_W      = 15;
  localparam int OUT_W       = 17;
  localparam int HOW_W       = 2;
  localparam int DIV_STEPS   = 16;
  localparam int DCNT_W      = 4;

  localparam logic [HOW_W-1:0] HOW_NONE     = 2'd0;
  localparam logic [HOW_W-1:0] HOW_LOGICAL  = 2'd1;
  localparam logic [HOW_W-1:0] HOW_DEVICE   = 2'd2;
  localparam logic [HOW_W-1:0] HOW_FALLBACK = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] lx;
    logic signed [COORD_W-1:0] ly;
    logic [SIZE_W-1:0]         lw;
    logic [SIZE_W-1:0]         lh;
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic [SIZE_W-1:0]         pw;
    logic [SIZE_W-1:0]         ph;
  } region_t;

  localparam int REGION_W = $bits(region_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             load_pt;
    logic             clr;
    logic             eval;
    logic             dev;
    logic             mul;
    logic             dstart;
    logic             dstep;
    logic             finish;
    logic [HOW_W-1:0] how;
  } ctrl_t;

  typedef struct packed {
    logic hit;
    logic found;
  } stat_t;

endpackage

FILE: hdl/pdrm_if.sv
// ----------------------------------------------------------------------------
// pdrm_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface pdrm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic [pdrm_pkg::SLOT_W-1:0]           slot;
  logic signed [pdrm_pkg::COORD_W-1:0]   region_x;
  logic signed [pdrm_pkg::COORD_W-1:0]   region_y;
  logic [pdrm_pkg::SIZE_W-1:0]           region_w;
  logic [pdrm_pkg::SIZE_W-1:0]           region_h;
  logic signed [pdrm_pkg::COORD_W-1:0]   origin_x;
  logic signed [pdrm_pkg::COORD_W-1:0]   origin_y;
  logic [pdrm_pkg::SIZE_W-1:0]           pixel_w;
  logic [pdrm_pkg::SIZE_W-1:0]           pixel_h;
  logic signed [pdrm_pkg::COORD_W-1:0]   point_x;
  logic signed [pdrm_pkg::COORD_W-1:0]   point_y;

  modport source (output valid, mode, slot, region_x, region_y, region_w, region_h,
                  origin_x, origin_y, pixel_w, pixel_h, point_x, point_y, input ready);
  modport sink (input valid, mode, slot, region_x, region_y, region_w, region_h,
                origin_x, origin_y, pixel_w, pixel_h, point_x, point_y, output ready);
endinterface

interface pdrm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pdrm_pkg::OUT_W-1:0] mapped_x;
  logic signed [pdrm_pkg::OUT_W-1:0] mapped_y;
  logic [pdrm_pkg::HOW_W-1:0]        how_mapped;

  modport source (output valid, mapped_x, mapped_y, how_mapped, input ready);
  modport sink (input valid, mapped_x, mapped_y, how_mapped, output ready);
endinterface

FILE: hdl/pdrm_ram.sv
// ----------------------------------------------------------------------------
// pdrm_ram
// Generic single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
module pdrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/pdrm_dpath.sv
// ----------------------------------------------------------------------------
// pdrm_dpath
// Region table, entry compare, scale multiplier, serial dividers, result.
// ----------------------------------------------------------------------------
module pdrm_dpath #(
  parameter int ENTRIES = pdrm_pkg::ENTRIES_DEF,
  parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                                clk,
  input  pdrm_pkg::ctrl_t                     cmd,
  input  logic [AW-1:0]                       raddr,
  input  logic [pdrm_pkg::SLOT_W-1:0]         slot,
  input  pdrm_pkg::region_t                   wregion,
  input  logic signed [pdrm_pkg::COORD_W-1:0] point_x,
  input  logic signed [pdrm_pkg::COORD_W-1:0] point_y,
  output pdrm_pkg::stat_t                     stat,
  output logic signed [pdrm_pkg::OUT_W-1:0]   mapped_x,
  output logic signed [pdrm_pkg::OUT_W-1:0]   mapped_y,
  output logic [pdrm_pkg::HOW_W-1:0]          how_mapped
);

  localparam int SW = pdrm_pkg::SIZE_W;
  localparam int CW = pdrm_pkg::COORD_W;
  localparam int OW = pdrm_pkg::OUT_W;

  pdrm_pkg::region_t rd;
  pdrm_pkg::region_t sel;
  logic [6:0]        slot_wide;
  logic              slot_ok;
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic              found;
  logic [OW-1:0]     best_dist;
  logic [SW-1:0]     offx;
  logic [SW-1:0]     offy;
  logic [2*SW-1:0]   prodx;
  logic [2*SW-1:0]   prody;
  logic [SW-1:0]     remx;
  logic [SW-1:0]     remy;
  logic [15:0]       qx;
  logic [15:0]       qy;

  assign slot_wide = {{(7 - pdrm_pkg::SLOT_W){1'b0}}, slot};
  assign slot_ok   = slot_wide < 7'(ENTRIES);

  pdrm_ram #(.WIDTH(pdrm_pkg::REGION_W), .DEPTH(ENTRIES), .AW(AW)) u_table (
    .clk   (clk),
    .we    (cmd.load && slot_ok),
    .waddr (slot_wide[AW-1:0]),
    .wdata (wregion),
    .raddr (raddr),
    .rdata (rd)
  );

  // Entry compare on the word just read.
  logic signed [OW-1:0] dx;
  logic signed [OW-1:0] dy;
  logic          usable;
  logic          in_log;
  logic          in_pix;
  logic [OW-1:0] distx;
  logic [OW-1:0] disty;
  logic [OW-1:0] ovr_dist;
  logic          better;

  always_comb begin
    dx     = OW'(px) - OW'(rd.lx);
    dy     = OW'(py) - OW'(rd.ly);
    usable = (rd.lw != '0) && (rd.lh != '0);
    in_log = !dx[OW-1] && (dx[15:0] < {1'b0, rd.lw})
          && !dy[OW-1] && (dy[15:0] < {1'b0, rd.lh});
    in_pix = !dx[OW-1] && (dx[15:0] < {1'b0, rd.pw})
          && !dy[OW-1] && (dy[15:0] < {1'b0, rd.ph});
    distx  = (dx[15:0] >= {1'b0, rd.lw}) ?
             ({1'b0, dx[15:0]} - {2'b0, rd.lw} + OW'(1)) : '0;
    disty  = (dy[15:0] >= {1'b0, rd.lh}) ?
             ({1'b0, dy[15:0]} - {2'b0, rd.lh} + OW'(1)) : '0;
    ovr_dist = distx + disty;
    better = usable && in_pix && (!found || (ovr_dist < best_dist));
    stat.hit   = cmd.dev ? better : (usable && in_log);
    stat.found = found;
  end

  // Rounded scale: (off * pix + log / 2) / log, quotient below 2^15.
  logic [2*SW:0] numx;
  logic [2*SW:0] numy;
  logic [SW:0]   trialx;
  logic [SW:0]   trialy;
  logic          gex;
  logic          gey;
  logic [SW:0]   subx;
  logic [SW:0]   suby;

  always_comb begin
    numx   = {1'b0, prodx} + {{(SW + 2){1'b0}}, sel.lw[SW-1:1]};
    numy   = {1'b0, prody} + {{(SW + 2){1'b0}}, sel.lh[SW-1:1]};
    trialx = {remx, qx[15]};
    trialy = {remy, qy[15]};
    gex    = trialx >= {1'b0, sel.lw};
    gey    = trialy >= {1'b0, sel.lh};
    subx   = trialx - {1'b0, sel.lw};
    suby   = trialy - {1'b0, sel.lh};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pt) begin
      px <= point_x;
      py <= point_y;
    end
    if (cmd.clr) begin
      found <= 1'b0;
    end else if (cmd.eval && stat.hit) begin
      found     <= 1'b1;
      sel       <= rd;
      best_dist <= ovr_dist;
      offx      <= dx[SW-1:0];
      offy      <= dy[SW-1:0];
    end
    if (cmd.mul) begin
      prodx <= offx * sel.pw;
      prody <= offy * sel.ph;
    end
    if (cmd.dstart) begin
      remx <= numx[2*SW:16];
      remy <= numy[2*SW:16];
      qx   <= numx[15:0];
      qy   <= numy[15:0];
    end else if (cmd.dstep) begin
      remx <= gex ? subx[SW-1:0] : trialx[SW-1:0];
      remy <= gey ? suby[SW-1:0] : trialy[SW-1:0];
      qx   <= {qx[14:0], gex};
      qy   <= {qy[14:0], gey};
    end
    if (cmd.finish) begin
      how_mapped <= cmd.how;
      if (!found) begin
        mapped_x <= OW'(px);
        mapped_y <= OW'(py);
      end else if (cmd.dev) begin
        mapped_x <= OW'(sel.ox) + OW'(offx);
        mapped_y <= OW'(sel.oy) + OW'(offy);
      end else begin
        mapped_x <= OW'(sel.ox) + OW'(qx);
        mapped_y <= OW'(sel.oy) + OW'(qy);
      end
    end
  end

endmodule

FILE: hdl/pdrm_ctrl.sv
// ----------------------------------------------------------------------------
// pdrm_ctrl
// Sequencer: table scan passes, convention order, divide steps, handshakes.
// ----------------------------------------------------------------------------
module pdrm_ctrl #(
  parameter int ENTRIES = pdrm_pkg::ENTRIES_DEF,
  parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int CW      = $clog2(ENTRIES + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_mode,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         cfg_we,
  input  logic [pdrm_pkg::CFG_W-1:0]   cfg_data,
  input  pdrm_pkg::stat_t              stat,
  output pdrm_pkg::ctrl_t              cmd,
  output logic [AW-1:0]                raddr
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DST  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [pdrm_pkg::CFG_W-1:0]  entries_in_use;
  logic [CW-1:0]               idx;
  logic [CW-1:0]               idx_next;
  logic [CW-1:0]               count;
  logic [pdrm_pkg::DCNT_W-1:0] dcnt;
  logic                        dev;
  logic                        dev_next;
  logic                        first;
  logic                        first_next;
  logic                        sticky;
  logic                        in_acc;
  logic                        fin_go;

  always_comb begin
    if (7'(entries_in_use) > 7'(ENTRIES)) begin
      count = CW'(ENTRIES);
    end else begin
      count = CW'(entries_in_use);
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);
  assign raddr    = idx[AW-1:0];

  always_comb begin
    state_next = state;
    idx_next   = idx;
    dev_next   = dev;
    first_next = first;
    cmd        = '0;
    cmd.dev    = dev;
    unique case (state)
      S_IDLE: begin
        cmd.load    = in_acc && !in_mode;
        cmd.load_pt = in_acc && in_mode;
        if (in_acc && in_mode) begin
          cmd.clr    = 1'b1;
          idx_next   = '0;
          dev_next   = sticky;
          first_next = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (idx >= count) begin
          // End of a pass: map, try the other convention, or give up.
          if (stat.found) begin
            state_next = dev ? S_FIN : S_MUL;
          end else if (first) begin
            cmd.clr    = 1'b1;
            dev_next   = !dev;
            first_next = 1'b0;
            idx_next   = '0;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          state_next = S_EV;
        end
      end
      S_EV: begin
        cmd.eval = 1'b1;
        if (!dev && stat.hit) begin
          state_next = S_MUL;
        end else begin
          idx_next   = idx + CW'(1);
          state_next = S_RD;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DST;
      end
      S_DST: begin
        cmd.dstart = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.dstep = 1'b1;
        if (dcnt == pdrm_pkg::DCNT_W'(pdrm_pkg::DIV_STEPS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = fin_go;
        if (!stat.found) begin
          cmd.how = pdrm_pkg::HOW_NONE;
        end else if (dev) begin
          cmd.how = pdrm_pkg::HOW_DEVICE;
        end else if (sticky) begin
          cmd.how = pdrm_pkg::HOW_FALLBACK;
        end else begin
          cmd.how = pdrm_pkg::HOW_LOGICAL;
        end
        if (fin_go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      entries_in_use <= '0;
      sticky         <= 1'b0;
      out_valid      <= 1'b0;
      idx            <= '0;
      dcnt           <= '0;
      dev            <= 1'b0;
      first          <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      dev   <= dev_next;
      first <= first_next;
      if (cfg_we) begin
        entries_in_use <= cfg_data;
      end
      if (state == S_DIV) begin
        dcnt <= dcnt + pdrm_pkg::DCNT_W'(1);
      end else begin
        dcnt <= '0;
      end
      if (fin_go && stat.found && dev) begin
        sticky <= 1'b1;
      end
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The convention flag never returns to logical-first once set.
  a_sticky_holds: assert property (@(posedge clk) disable iff (rst) !$fell(sticky))
    else $error("device-local flag cleared");

  // A query needs at least one scan step before any result can appear.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_mode) |=> !fin_go)
    else $error("result issued right after query");

  // Finishing a query always presents a result in the next cycle.
  a_fin_valid: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> (out_valid && (state == S_IDLE)))
    else $error("finished query left no result");

  // The divider only runs after a logical hit.
  a_div_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (stat.found && !dev))
    else $error("divide without a logical hit");

endmodule

FILE: hdl/point_to_display_region_mapper_core.sv
// ----------------------------------------------------------------------------
// point_to_display_region_mapper_core
// Maps points to pixel coordinates through a table of display regions.
// ----------------------------------------------------------------------------
// A load item (mode 0) writes one table entry, a slot at or beyond ENTRIES
// being ignored, and gives no result. A query item (mode 1) scans the first
// entries_in_use entries, no more than ENTRIES, once for the convention tried
// first and, on a miss, once more for the other; a logical pass stops at its
// first hit. A logical hit then runs a multiply, a divider setup and 16
// divide steps on the rounded scale, both axes in parallel, and a final step
// loads the result. The input is taken only while the sequencer is idle; the
// result waits in an output register, loads are accepted meanwhile, and a
// result that is not taken holds the next query in its finishing step.
module point_to_display_region_mapper_core #(
  parameter int ENTRIES = pdrm_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  pdrm_in_if.sink                    in_ch,
  pdrm_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [pdrm_pkg::CFG_W-1:0] cfg_data
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  pdrm_pkg::ctrl_t   cmd;
  pdrm_pkg::stat_t   stat;
  pdrm_pkg::region_t wregion;
  logic [AW-1:0]     raddr;

  always_comb begin
    wregion.lx = in_ch.region_x;
    wregion.ly = in_ch.region_y;
    wregion.lw = in_ch.region_w;
    wregion.lh = in_ch.region_h;
    wregion.ox = in_ch.origin_x;
    wregion.oy = in_ch.origin_y;
    wregion.pw = in_ch.pixel_w;
    wregion.ph = in_ch.pixel_h;
  end

  pdrm_ctrl #(.ENTRIES(ENTRIES), .AW(AW), .CW(CW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .cmd       (cmd),
    .raddr     (raddr)
  );

  pdrm_dpath #(.ENTRIES(ENTRIES), .AW(AW)) u_dpath (
    .clk        (clk),
    .cmd        (cmd),
    .raddr      (raddr),
    .slot       (in_ch.slot),
    .wregion    (wregion),
    .point_x    (in_ch.point_x),
    .point_y    (in_ch.point_y),
    .stat       (stat),
    .mapped_x   (out_ch.mapped_x),
    .mapped_y   (out_ch.mapped_y),
    .how_mapped (out_ch.how_mapped)
  );

endmodule
